[sv/lcte_pkg.sv]
// shared types and constants for the leb128 chunk text extractor
package lcte_pkg;

    localparam int unsigned QUEUE_DEPTH      = 2;
    localparam int unsigned LEB_MAX_BYTES    = 9;
    localparam int unsigned LEB_PAYLOAD_BITS = 7;
    localparam int unsigned ID_WIDTH         = 64;
    localparam int unsigned IN_TDATA_WIDTH   = 136;
    localparam int unsigned IN_TUSER_WIDTH   = 3;

    // tuser bit positions on the input side
    localparam int unsigned TUSER_FIRST = 0;
    localparam int unsigned TUSER_HEAD  = 1;
    localparam int unsigned TUSER_TAIL  = 2;

    // one classified input word
    typedef struct packed {
        logic [ID_WIDTH-1:0] thread_ident;
        logic [ID_WIDTH-1:0] process_ident;
        logic [7:0]          data_byte;
        logic                leb_more;
        logic                packet_first;
        logic                packet_last;
        logic                head_flag;
        logic                tail_flag;
    } item_t;

endpackage

[sv/leb128_chunk_text_extractor.sv]
// top level of the leb128 chunk text extractor
// extracts the data bytes of text chunks from a stream of log packet payload
// bytes, one byte per word; each packet carries key/size/data chunks with the
// key and size as leb128 values, and the data of chunks whose key equals
// text_key comes out one byte per output word, tlast marking the last byte of
// a chunk segment inside a packet; chunks that run past a packet end are
// carried on into the next non-head packet of the same process and thread;
// the block sustains one input word per clock while the output is not stalled:
// the front stage registers each word, a short queue parts it from the back
// stage, and the back stage updates the whole parser state at once for each
// byte, which sets the rate; a text word passes the front register, the queue
// and the output register on its way out, and output stalls hold it back
// further; during a stall the front register and the queue (two words by
// default) keep taking input words until they are full; text_key should be
// written only while idle
module leb128_chunk_text_extractor #(
    parameter int unsigned QueueDepth = lcte_pkg::QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration: text chunk key
    input  logic                                text_key_we,
    input  logic [7:0]                          text_key_wdata,
    // input words
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // data_byte [7:0], process_ident [71:8], thread_ident [135:72]
    input  logic [lcte_pkg::IN_TDATA_WIDTH-1:0] s_axis_tdata,
    // packet_first [0], head_flag [1], tail_flag [2]
    input  logic [lcte_pkg::IN_TUSER_WIDTH-1:0] s_axis_tuser,
    // packet_last
    input  logic                                s_axis_tlast,
    // output words
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // text_byte [7:0]
    output logic [7:0]                          m_axis_tdata,
    // segment_end
    output logic                                m_axis_tlast
);

    // front to queue
    logic            fq_valid;
    logic            fq_ready;
    lcte_pkg::item_t fq_item;

    // queue to back
    logic            qb_valid;
    logic            qb_ready;
    lcte_pkg::item_t qb_item;

    // registers and classifies each input word
    lcte_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .item_valid    (fq_valid),
        .item_ready    (fq_ready),
        .item          (fq_item)
    );

    // decouples the front from output stalls
    lcte_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    // parser state machine and output register
    lcte_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .text_key_we    (text_key_we),
        .text_key_wdata (text_key_wdata),
        .item_valid     (qb_valid),
        .item_ready     (qb_ready),
        .item           (qb_item),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast)
    );

endmodule

[sv/lcte_front.sv]
// front stage: accepts input words and classifies them into queue items
module lcte_front (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  logic [lcte_pkg::IN_TDATA_WIDTH-1:0]      s_axis_tdata,
    input  logic [lcte_pkg::IN_TUSER_WIDTH-1:0]      s_axis_tuser,
    input  logic                                     s_axis_tlast,
    output logic                                     item_valid,
    input  logic                                     item_ready,
    output lcte_pkg::item_t                          item
);

    logic            valid_reg;
    logic            valid_next;
    lcte_pkg::item_t item_reg;
    lcte_pkg::item_t item_next;
    logic            take;

    assign s_axis_tready = !valid_reg || item_ready;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        item_next               = item_reg;
        valid_next              = valid_reg;
        if (item_ready)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            item_next.data_byte     = s_axis_tdata[7:0];
            item_next.leb_more      = s_axis_tdata[7];
            item_next.process_ident = s_axis_tdata[71:8];
            item_next.thread_ident  = s_axis_tdata[135:72];
            item_next.packet_first  = s_axis_tuser[lcte_pkg::TUSER_FIRST];
            item_next.head_flag     = s_axis_tuser[lcte_pkg::TUSER_HEAD];
            item_next.tail_flag     = s_axis_tuser[lcte_pkg::TUSER_TAIL];
            item_next.packet_last   = s_axis_tlast;
            valid_next              = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[sv/lcte_queue.sv]
// short queue of classified items between front and back
module lcte_queue #(
    parameter int unsigned Depth = lcte_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  lcte_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output lcte_pkg::item_t pop_item
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    lcte_pkg::item_t mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != CntW'(Depth));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_ready && pop_valid;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[sv/lcte_back.sv]
// back stage: packet and chunk parser with registered text output
module lcte_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            text_key_we,
    input  logic [7:0]      text_key_wdata,
    input  logic            item_valid,
    output logic            item_ready,
    input  lcte_pkg::item_t item,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [7:0]      m_axis_tdata,
    output logic            m_axis_tlast
);

    typedef enum logic [1:0] {
        MODE_PARSE = 2'd0,
        MODE_CARRY = 2'd1,
        MODE_DROP  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PH_KEY  = 2'd0,
        PH_SIZE = 2'd1,
        PH_DATA = 2'd2,
        PH_STOP = 2'd3
    } phase_t;

    localparam int unsigned IdW = lcte_pkg::ID_WIDTH;

    logic [7:0]     text_key_reg;
    mode_t          mode_reg, mode_next;
    phase_t         phase_reg, phase_next;
    logic [63:0]    accum_reg, accum_next;
    logic [3:0]     shift_reg, shift_next;
    logic [63:0]    remain_reg, remain_next;
    logic           is_text_reg, is_text_next;
    logic [IdW-1:0] saved_proc_reg, saved_proc_next;
    logic [IdW-1:0] saved_thr_reg, saved_thr_next;
    logic [63:0]    carry_reg, carry_next;
    logic           carry_text_reg, carry_text_next;
    logic           parsed_reg, parsed_next;
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_data_reg, out_data_next;
    logic           out_last_reg, out_last_next;
    logic           take;

    assign item_ready = !out_valid_reg || m_axis_tready;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        logic [5:0] sh_amt;
        logic       emit;
        logic       seg;

        mode_next       = mode_reg;
        phase_next      = phase_reg;
        accum_next      = accum_reg;
        shift_next      = shift_reg;
        remain_next     = remain_reg;
        is_text_next    = is_text_reg;
        saved_proc_next = saved_proc_reg;
        saved_thr_next  = saved_thr_reg;
        carry_next      = carry_reg;
        carry_text_next = carry_text_reg;
        parsed_next     = parsed_reg;
        emit            = 1'b0;
        seg             = 1'b0;
        sh_amt          = {2'b00, shift_reg} * 6'd7;

        if (item.packet_first)
        begin
            phase_next   = PH_KEY;
            accum_next   = '0;
            shift_next   = '0;
            remain_next  = '0;
            is_text_next = 1'b0;
            parsed_next  = 1'b0;
            if (item.head_flag)
            begin
                mode_next = MODE_PARSE;
            end
            else if (item.process_ident == saved_proc_reg &&
                     item.thread_ident == saved_thr_reg)
            begin
                mode_next = (carry_reg != '0) ? MODE_CARRY : MODE_PARSE;
            end
            else
            begin
                mode_next = MODE_DROP;
            end
        end

        if (mode_next == MODE_CARRY)
        begin
            if (carry_next != '0)
            begin
                carry_next = carry_next - 64'd1;
            end
            if (carry_text_reg)
            begin
                emit = 1'b1;
                seg  = (carry_next == '0) || item.packet_last;
            end
            if (carry_next == '0)
            begin
                mode_next = MODE_PARSE;
            end
        end
        else if (mode_next == MODE_PARSE)
        begin
            parsed_next = 1'b1;
            if (phase_next == PH_DATA && remain_next == '0)
            begin
                phase_next = PH_KEY;
            end
            sh_amt = {2'b00, shift_next} * 6'd7;
            if (phase_next == PH_KEY || phase_next == PH_SIZE)
            begin
                accum_next = accum_next |
                    (64'(item.data_byte[lcte_pkg::LEB_PAYLOAD_BITS-1:0]) << sh_amt);
                if (!item.leb_more)
                begin
                    if (phase_next == PH_KEY)
                    begin
                        is_text_next = (accum_next == {56'd0, text_key_reg});
                        phase_next   = PH_SIZE;
                    end
                    else
                    begin
                        remain_next = accum_next;
                        phase_next  = PH_DATA;
                    end
                    accum_next = '0;
                    shift_next = '0;
                end
                else
                begin
                    shift_next = shift_next + 4'd1;
                    if (shift_next >= 4'(lcte_pkg::LEB_MAX_BYTES))
                    begin
                        phase_next = PH_STOP;
                        accum_next = '0;
                        shift_next = '0;
                    end
                end
            end
            else if (phase_next == PH_DATA)
            begin
                remain_next = remain_next - 64'd1;
                if (is_text_next)
                begin
                    emit = 1'b1;
                    seg  = (remain_next == '0) || item.packet_last;
                end
            end
        end

        if (item.packet_last)
        begin
            if (mode_next != MODE_DROP && parsed_next && !item.tail_flag)
            begin
                saved_proc_next = item.process_ident;
                saved_thr_next  = item.thread_ident;
                if (phase_next == PH_DATA)
                begin
                    carry_next      = remain_next;
                    carry_text_next = is_text_next;
                end
                else
                begin
                    carry_next      = '0;
                    carry_text_next = 1'b0;
                end
            end
            mode_next = MODE_DROP;
        end

        out_valid_next = m_axis_tready ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (take && emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = item.data_byte;
            out_last_next  = seg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_key_reg   <= '0;
            mode_reg       <= MODE_PARSE;
            phase_reg      <= PH_KEY;
            accum_reg      <= '0;
            shift_reg      <= '0;
            remain_reg     <= '0;
            is_text_reg    <= 1'b0;
            saved_proc_reg <= '0;
            saved_thr_reg  <= '0;
            carry_reg      <= '0;
            carry_text_reg <= 1'b0;
            parsed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (text_key_we)
            begin
                text_key_reg <= text_key_wdata;
            end
            if (take)
            begin
                mode_reg       <= mode_next;
                phase_reg      <= phase_next;
                accum_reg      <= accum_next;
                shift_reg      <= shift_next;
                remain_reg     <= remain_next;
                is_text_reg    <= is_text_next;
                saved_proc_reg <= saved_proc_next;
                saved_thr_reg  <= saved_thr_next;
                carry_reg      <= carry_next;
                carry_text_reg <= carry_text_next;
                parsed_reg     <= parsed_next;
            end
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

[sv/lcte_checker.sv]
// port-level checks for the leb128 chunk text extractor, bound to the top level
module lcte_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // input words minus output words, saturating at seven and at zero
    logic [2:0] credit_reg;
    logic [2:0] credit_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        credit_next = credit_reg;
        if (in_acc && !out_acc && credit_reg != 3'd7)
        begin
            credit_next = credit_reg + 3'd1;
        end
        else if (out_acc && !in_acc && credit_reg != 3'd0)
        begin
            credit_next = credit_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    // no output word without an earlier input word
    a_out_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> credit_reg != 3'd0)
        else $error("output word with no input word behind it");

    // leaving reset: output empty and input open
    a_reset_state: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid && s_axis_tready)
        else $error("bad handshake state after reset");

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

endmodule

bind leb128_chunk_text_extractor lcte_checker u_checker (.*);
